>>> rtl/core/escaped_frame_receiver_core_macros.svh
// Assertion macros shared by the frame receiver RTL.
`ifndef ESCAPED_FRAME_RECEIVER_CORE_MACROS_SVH
`define ESCAPED_FRAME_RECEIVER_CORE_MACROS_SVH

// Checked on every clock edge outside reset.
`define EFR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define EFR_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/core/efr_pkg.sv
// Shared types and constants of the escaped frame receiver.
`default_nettype none
package efr_pkg;

  localparam int MAX_FRAME = 1024;
  localparam int CNT_W     = $clog2(MAX_FRAME + 1);
  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W     = $clog2(FIFO_DEPTH);
  localparam int LVL_W     = $clog2(FIFO_DEPTH + 1);

  localparam logic [7:0] FLAG_BYTE    = 8'h7e;
  localparam logic [7:0] ESC_BYTE     = 8'h7d;
  localparam logic [7:0] ESC_FOR_ESC  = 8'h01;
  localparam logic [7:0] ESC_FOR_FLAG = 8'h02;
  localparam logic [7:0] SUM_INVERT   = 8'hff;

  localparam logic [1:0] ST_GOOD      = 2'd0;
  localparam logic [1:0] ST_BAD_CHECK = 2'd1;
  localparam logic [1:0] ST_SHORT     = 2'd2;
  localparam logic [1:0] ST_LONG      = 2'd3;

  typedef struct packed {
    logic [7:0] data;
    logic       frame_end;
    logic [1:0] status;
  } res_t;

  // Up to two result words written into the output queue in one cycle.
  typedef struct packed {
    logic [1:0] n;
    res_t       d0;
    res_t       d1;
  } push_t;

endpackage
`default_nettype wire

>>> rtl/core/efr_out_fifo.sv
// Four-entry result queue that takes up to two words per cycle and gives one.
`default_nettype none
`include "escaped_frame_receiver_core_macros.svh"
module efr_out_fifo (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire efr_pkg::push_t push,
  input  wire logic          pop,
  output efr_pkg::res_t      head,
  output logic               not_empty,
  output logic               room2
);

  efr_pkg::res_t mem [efr_pkg::FIFO_DEPTH];

  logic [efr_pkg::PTR_W-1:0] wptr_r, wptr_nxt;
  logic [efr_pkg::PTR_W-1:0] rptr_r, rptr_nxt;
  logic [efr_pkg::LVL_W-1:0] lvl_r, lvl_nxt;
  logic [efr_pkg::PTR_W-1:0] wptr_p1;
  logic                      do_pop;

  assign wptr_p1   = wptr_r + efr_pkg::PTR_W'(1);
  assign not_empty = (lvl_r != '0);
  assign room2     = (lvl_r <= efr_pkg::LVL_W'(efr_pkg::FIFO_DEPTH - 2));
  assign head      = mem[rptr_r];
  assign do_pop    = pop && not_empty;

  always_comb begin
    wptr_nxt = wptr_r + efr_pkg::PTR_W'(push.n);
    rptr_nxt = do_pop ? rptr_r + efr_pkg::PTR_W'(1) : rptr_r;
    lvl_nxt  = lvl_r + efr_pkg::LVL_W'(push.n) - efr_pkg::LVL_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      lvl_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      lvl_r  <= lvl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      mem[wptr_r] <= push.d0;
    end
    if (push.n == 2'd2) begin
      mem[wptr_p1] <= push.d1;
    end
  end

  `EFR_ASSERT(a_no_overfill, (push.n != 2'd0) |-> room2, "write into a full queue")
  `EFR_ASSERT(a_lvl_bound, lvl_r <= efr_pkg::LVL_W'(efr_pkg::FIFO_DEPTH), "queue level out of range")
  `EFR_ASSERT(a_ptr_gap, lvl_r[efr_pkg::PTR_W-1:0] == (wptr_r - rptr_r), "pointers disagree with level")

endmodule
`default_nettype wire

>>> rtl/core/escaped_frame_receiver_core.sv
// Top level of the escaped frame receiver: unescaping, frame checks and result queue.
//
//  channel | ports                                         | direction
//  --------+-----------------------------------------------+----------
//  input   | in_valid, in_ready, in_byte[7:0]              | in
//  result  | out_valid, out_ready, out_byte[7:0],          | out
//          | out_frame_end, out_status[1:0]                |
//
// A raw word is decoded in the cycle it is accepted; its zero, one or two results
// enter a four-entry queue that drives the result ports.
// One raw word per cycle is taken while the queue has room for two results; a
// word that yields two results fills the queue faster than it drains, one word per cycle while out_ready is high.
// Reset (rst_n low at a clock edge) empties the queue and clears all frame state.
// A stall on the result side fills the queue and then holds in_ready low.
`default_nettype none
`include "escaped_frame_receiver_core_macros.svh"
module escaped_frame_receiver_core (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_byte,
  output logic            out_frame_end,
  output logic [1:0]      out_status
);

  typedef struct packed {
    logic [efr_pkg::CNT_W-1:0] cnt;
    logic [7:0]                sum;
    logic [7:0]                chk;
    logic                      ovf;
  } frm_t;

  localparam logic [efr_pkg::CNT_W-1:0] CNT_MAX  = efr_pkg::CNT_W'(efr_pkg::MAX_FRAME);
  localparam logic [efr_pkg::CNT_W-1:0] CNT_HDR  = efr_pkg::CNT_W'(4);

  function automatic frm_t take_f(frm_t s, logic [7:0] b);
    frm_t r;
    r = s;
    if (s.cnt >= CNT_MAX) begin
      r.ovf = 1'b1;
    end else begin
      if (s.cnt == '0) begin
        r.chk = b;
      end else begin
        r.sum = s.sum + b;
      end
      r.cnt = s.cnt + efr_pkg::CNT_W'(1);
    end
    return r;
  endfunction

  function automatic logic emit_f(frm_t s);
    return (s.cnt < CNT_MAX) && (s.cnt >= CNT_HDR);
  endfunction

  frm_t frm_r, frm_nxt;
  logic par_r, par_nxt;
  logic esc_r, esc_nxt;

  logic          in_fire;
  logic          is_close;
  logic          ta_v, tb_v;
  logic [7:0]    ta_b;
  logic          ea, eb;
  frm_t          s1, s2;
  logic [1:0]    st;
  efr_pkg::res_t res_a, res_b, res_end;
  efr_pkg::push_t push;
  efr_pkg::res_t head;
  logic          room2;

  assign in_fire = in_valid && in_ready;

  always_comb begin
    par_nxt  = par_r;
    esc_nxt  = esc_r;
    is_close = 1'b0;
    ta_v     = 1'b0;
    ta_b     = in_byte;
    tb_v     = 1'b0;
    if (in_byte == efr_pkg::FLAG_BYTE) begin
      par_nxt = ~par_r;
      if (par_r) begin
        // A dangling escape at the closing flag counts as a plain 7D.
        is_close = 1'b1;
        ta_v     = esc_r;
        ta_b     = efr_pkg::ESC_BYTE;
      end
    end else if (esc_r) begin
      esc_nxt = 1'b0;
      ta_v    = 1'b1;
      if (in_byte == efr_pkg::ESC_FOR_FLAG) begin
        ta_b = efr_pkg::FLAG_BYTE;
      end else begin
        ta_b = efr_pkg::ESC_BYTE;
        tb_v = (in_byte != efr_pkg::ESC_FOR_ESC);
      end
    end else if (in_byte == efr_pkg::ESC_BYTE) begin
      esc_nxt = 1'b1;
    end else begin
      ta_v = 1'b1;
    end

    s1 = ta_v ? take_f(frm_r, ta_b) : frm_r;
    ea = ta_v && emit_f(frm_r);
    s2 = tb_v ? take_f(s1, in_byte) : s1;
    eb = tb_v && emit_f(s1);

    priority if (s2.ovf) begin
      st = efr_pkg::ST_LONG;
    end else if (s2.cnt < CNT_HDR) begin
      st = efr_pkg::ST_SHORT;
    end else if ((s2.sum ^ efr_pkg::SUM_INVERT) != s2.chk) begin
      st = efr_pkg::ST_BAD_CHECK;
    end else begin
      st = efr_pkg::ST_GOOD;
    end

    if (is_close) begin
      frm_nxt = '0;
      esc_nxt = 1'b0;
    end else begin
      frm_nxt = s2;
    end

    res_a   = '{data: ta_b,    frame_end: 1'b0, status: efr_pkg::ST_GOOD};
    res_b   = '{data: in_byte, frame_end: 1'b0, status: efr_pkg::ST_GOOD};
    res_end = '{data: 8'h00,   frame_end: 1'b1, status: st};

    // A close and a second unescaped word never come from the same raw word.
    push.n  = in_fire ? 2'(ea) + 2'(eb) + 2'(is_close) : 2'd0;
    push.d0 = ea ? res_a : (eb ? res_b : res_end);
    push.d1 = (ea && eb) ? res_b : res_end;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frm_r <= '0;
      par_r <= 1'b0;
      esc_r <= 1'b0;
    end else if (in_fire) begin
      frm_r <= frm_nxt;
      par_r <= par_nxt;
      esc_r <= esc_nxt;
    end
  end

  efr_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .pop       (out_ready),
    .head      (head),
    .not_empty (out_valid),
    .room2     (room2)
  );

  assign in_ready      = room2;
  assign out_byte      = head.data;
  assign out_frame_end = head.frame_end;
  assign out_status    = head.status;

  `EFR_ASSERT(a_close_clears, (in_fire && is_close) |=> (frm_r == '0 && !esc_r), "frame state kept after close")
  `EFR_ASSERT(a_cnt_bound, frm_r.cnt <= CNT_MAX, "word count beyond buffer size")
  `EFR_ASSERT(a_end_zero, (out_valid && out_frame_end) |-> (out_byte == 8'h00), "end word carries data")

endmodule
`default_nettype wire

>>> tb/escaped_frame_receiver_core_test.sv
// Self-checking testbench for the escaped frame receiver: directed table, then random traffic.
`timescale 1ns / 1ps
module escaped_frame_receiver_core_test;

  localparam int NUM_DIR        = 27;
  localparam int RAND_ITEMS     = 700;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 16;

  typedef enum int {FR_GOOD, FR_BAD_CHECK, FR_SHORT} frame_kind_t;

  typedef struct {
    logic [7:0]     raw;
    bit             typed;
    int             n;
    efr_pkg::res_t  w0;
    efr_pkg::res_t  w1;
  } stim_row_t;

  localparam efr_pkg::res_t NO_WORD   = '0;
  localparam efr_pkg::res_t END_GOOD  = '{8'h00, 1'b1, efr_pkg::ST_GOOD};
  localparam efr_pkg::res_t END_BAD   = '{8'h00, 1'b1, efr_pkg::ST_BAD_CHECK};
  localparam efr_pkg::res_t END_SHORT = '{8'h00, 1'b1, efr_pkg::ST_SHORT};
  localparam efr_pkg::res_t PAY_ESC   = '{efr_pkg::ESC_BYTE, 1'b0, efr_pkg::ST_GOOD};

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_byte = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_byte;
  logic       out_frame_end;
  logic [1:0] out_status;

  // Predictor state.
  logic                      parity = 1'b0;
  logic                      esc_pend = 1'b0;
  logic [efr_pkg::CNT_W-1:0] kept_cnt = '0;
  logic [7:0]                sum_acc = '0;
  logic [7:0]                check_byte = '0;
  logic                      overflow = 1'b0;

  efr_pkg::res_t step_words[$];
  efr_pkg::res_t unstuffed_due[$];
  int   taken = 0;
  int   fail_count = 0;
  int   quiet_cycles = 0;
  int   sent_items = 0;
  bit   calm = 1'b0;
  bit   flag_odd = 1'b0;

  // Opening flags, a good frame with every escape form, a bad checksum with an escape
  // left open at the close, and an escape held across an opening flag.
  stim_row_t dir_rows [NUM_DIR] = '{
    '{efr_pkg::FLAG_BYTE, 1'b1, 0, NO_WORD, NO_WORD},
    '{efr_pkg::FLAG_BYTE, 1'b1, 1, END_SHORT, NO_WORD},
    '{efr_pkg::FLAG_BYTE, 1'b1, 0, NO_WORD, NO_WORD},
    '{8'h82, 1'b0, 0, NO_WORD, NO_WORD},
    '{8'h01, 1'b0, 0, NO_WORD, NO_WORD},
    '{8'h02, 1'b0, 0, NO_WORD, NO_WORD},
    '{8'h03, 1'b0, 0, NO_WORD, NO_WORD},
    '{efr_pkg::ESC_BYTE, 1'b1, 0, NO_WORD, NO_WORD},
    '{efr_pkg::ESC_FOR_ESC, 1'b0, 0, NO_WORD, NO_WORD},
    '{efr_pkg::ESC_BYTE, 1'b1, 0, NO_WORD, NO_WORD},
    '{efr_pkg::ESC_FOR_FLAG, 1'b0, 0, NO_WORD, NO_WORD},
    '{efr_pkg::ESC_BYTE, 1'b1, 0, NO_WORD, NO_WORD},
    '{8'h00, 1'b0, 0, NO_WORD, NO_WORD},
    '{8'hff, 1'b0, 0, NO_WORD, NO_WORD},
    '{8'h00, 1'b0, 0, NO_WORD, NO_WORD},
    '{efr_pkg::FLAG_BYTE, 1'b1, 1, END_GOOD, NO_WORD},
    '{efr_pkg::FLAG_BYTE, 1'b1, 0, NO_WORD, NO_WORD},
    '{8'h00, 1'b0, 0, NO_WORD, NO_WORD},
    '{8'h00, 1'b0, 0, NO_WORD, NO_WORD},
    '{8'h00, 1'b0, 0, NO_WORD, NO_WORD},
    '{8'h00, 1'b0, 0, NO_WORD, NO_WORD},
    '{efr_pkg::ESC_BYTE, 1'b1, 0, NO_WORD, NO_WORD},
    '{efr_pkg::FLAG_BYTE, 1'b1, 2, PAY_ESC, END_BAD},
    '{efr_pkg::ESC_BYTE, 1'b1, 0, NO_WORD, NO_WORD},
    '{efr_pkg::FLAG_BYTE, 1'b1, 0, NO_WORD, NO_WORD},
    '{efr_pkg::ESC_FOR_FLAG, 1'b0, 0, NO_WORD, NO_WORD},
    '{efr_pkg::FLAG_BYTE, 1'b1, 1, END_SHORT, NO_WORD}
  };

  escaped_frame_receiver_core dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_byte       (in_byte),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_byte      (out_byte),
    .out_frame_end (out_frame_end),
    .out_status    (out_status)
  );

  always #10 clk = ~clk;

  always @(negedge clk) begin
    out_ready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 24);
  end

  task automatic keep_byte(input logic [7:0] b);
    efr_pkg::res_t w;
    if (kept_cnt >= efr_pkg::MAX_FRAME) begin
      overflow = 1'b1;
    end else begin
      if (kept_cnt == 0) check_byte = b;
      else sum_acc = sum_acc + b;
      if (kept_cnt >= 4) begin
        w = '{b, 1'b0, efr_pkg::ST_GOOD};
        step_words.push_back(w);
      end
      kept_cnt = kept_cnt + 1'b1;
    end
  endtask

  task automatic unstuff_byte(input logic [7:0] raw);
    logic [1:0]    st;
    efr_pkg::res_t w;
    if (raw == efr_pkg::FLAG_BYTE) begin
      parity = ~parity;
      if (!parity) begin
        if (esc_pend) keep_byte(efr_pkg::ESC_BYTE);
        if (overflow) st = efr_pkg::ST_LONG;
        else if (kept_cnt < 4) st = efr_pkg::ST_SHORT;
        else if ((sum_acc ^ efr_pkg::SUM_INVERT) != check_byte) st = efr_pkg::ST_BAD_CHECK;
        else st = efr_pkg::ST_GOOD;
        w = '{8'h00, 1'b1, st};
        step_words.push_back(w);
        esc_pend = 1'b0;
        kept_cnt = '0;
        sum_acc = '0;
        check_byte = '0;
        overflow = 1'b0;
      end
    end else if (esc_pend) begin
      esc_pend = 1'b0;
      if (raw == efr_pkg::ESC_FOR_ESC) begin
        keep_byte(efr_pkg::ESC_BYTE);
      end else if (raw == efr_pkg::ESC_FOR_FLAG) begin
        keep_byte(efr_pkg::FLAG_BYTE);
      end else begin
        keep_byte(efr_pkg::ESC_BYTE);
        keep_byte(raw);
      end
    end else if (raw == efr_pkg::ESC_BYTE) begin
      esc_pend = 1'b1;
    end else begin
      keep_byte(raw);
    end
  endtask

  always @(posedge clk) begin : check_words
    efr_pkg::res_t want;
    bit            busy;
    if (rst_n) begin
      busy = 1'b0;
      if (in_valid && in_ready) begin
        step_words.delete();
        unstuff_byte(in_byte);
        if (taken < NUM_DIR && dir_rows[taken].typed) begin
          if (dir_rows[taken].n > 0) unstuffed_due.push_back(dir_rows[taken].w0);
          if (dir_rows[taken].n > 1) unstuffed_due.push_back(dir_rows[taken].w1);
        end else begin
          foreach (step_words[k]) unstuffed_due.push_back(step_words[k]);
        end
        taken++;
        busy = 1'b1;
      end
      if (out_valid && out_ready) begin
        busy = 1'b1;
        if (unstuffed_due.size() == 0) begin
          $error("unexpected word: out_byte %0h out_frame_end %0b out_status %0d",
                 out_byte, out_frame_end, out_status);
          fail_count++;
        end else begin
          want = unstuffed_due.pop_front();
          if (out_byte !== want.data) begin
            $error("out_byte expected %0h actual %0h", want.data, out_byte);
            fail_count++;
          end
          if (out_frame_end !== want.frame_end) begin
            $error("out_frame_end expected %0b actual %0b", want.frame_end, out_frame_end);
            fail_count++;
          end
          if (out_status !== want.status) begin
            $error("out_status expected %0d actual %0d", want.status, out_status);
            fail_count++;
          end
        end
      end
      quiet_cycles = busy ? 0 : quiet_cycles + 1;
    end
  end

  initial begin
    while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("TB_ERROR");
    $finish;
  end

  task automatic put_raw(input logic [7:0] b);
    @(negedge clk);
    while (!calm && $urandom_range(0, 99) < 24) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    do @(posedge clk); while (!in_ready);
    if (b == efr_pkg::FLAG_BYTE) flag_odd = ~flag_odd;
    sent_items++;
  endtask

  // Biased toward the flag and escape codes so that every escape path is hit often.
  function automatic logic [7:0] pick_byte();
    if ($urandom_range(0, 3) != 0) return 8'($urandom_range(0, 255));
    unique case ($urandom_range(0, 3))
      0: return efr_pkg::FLAG_BYTE;
      1: return efr_pkg::ESC_BYTE;
      2: return efr_pkg::ESC_FOR_ESC;
      default: return efr_pkg::ESC_FOR_FLAG;
    endcase
  endfunction

  task automatic send_frame(input int plen, input frame_kind_t kind);
    logic [7:0] u[$];
    logic [7:0] acc;
    int         i;
    acc = '0;
    if (kind == FR_SHORT) begin
      repeat ($urandom_range(0, 3)) u.push_back(pick_byte());
    end else begin
      repeat (3 + plen) u.push_back(pick_byte());
      foreach (u[k]) acc = acc + u[k];
      acc = acc ^ efr_pkg::SUM_INVERT;
      if (kind == FR_BAD_CHECK) acc = acc ^ 8'($urandom_range(1, 255));
      u.push_front(acc);
    end
    put_raw(efr_pkg::FLAG_BYTE);
    i = 0;
    while (i < u.size()) begin
      if (u[i] == efr_pkg::FLAG_BYTE) begin
        put_raw(efr_pkg::ESC_BYTE);
        put_raw(efr_pkg::ESC_FOR_FLAG);
      end else if (u[i] == efr_pkg::ESC_BYTE) begin
        // A bare escape may stand before a byte that is not an escape code,
        // or at the very end where the closing flag releases it.
        if (i == u.size() - 1 && $urandom_range(0, 1) == 1) begin
          put_raw(efr_pkg::ESC_BYTE);
        end else if (i < u.size() - 1 && u[i+1] != efr_pkg::ESC_FOR_ESC
                     && u[i+1] != efr_pkg::ESC_FOR_FLAG
                     && u[i+1] != efr_pkg::FLAG_BYTE && $urandom_range(0, 1) == 1) begin
          put_raw(efr_pkg::ESC_BYTE);
          put_raw(u[i+1]);
          i++;
        end else begin
          put_raw(efr_pkg::ESC_BYTE);
          put_raw(efr_pkg::ESC_FOR_ESC);
        end
      end else begin
        put_raw(u[i]);
      end
      i++;
    end
    put_raw(efr_pkg::FLAG_BYTE);
  endtask

  task automatic hold_until_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (unstuffed_due.size() != 0) @(posedge clk);
  endtask

  initial begin
    int  pick;
    int  plen;
    bit  paused;
    paused = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[r]) put_raw(dir_rows[r].raw);

    while (sent_items < NUM_DIR + RAND_ITEMS) begin
      calm = (sent_items > 300 && sent_items < 450);
      if (!paused && sent_items > 200) begin
        paused = 1'b1;
        hold_until_drained();
      end
      plen = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 8);
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        send_frame(plen, FR_GOOD);
      end else if (pick < 70) begin
        send_frame(plen, FR_BAD_CHECK);
      end else if (pick < 82) begin
        send_frame(0, FR_SHORT);
      end else begin
        // Noise, which may open or break a frame; close it so later frames line up.
        repeat ($urandom_range(1, 12)) put_raw(pick_byte());
        if (flag_odd) put_raw(efr_pkg::FLAG_BYTE);
      end
    end
    calm = 1'b0;

    hold_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
